// ===== rtl/core/named_binary_tag_stream_parser_defines.svh =====
// assertion helpers for the tag stream parser
`ifndef NAMED_BINARY_TAG_STREAM_PARSER_DEFINES_SVH
`define NAMED_BINARY_TAG_STREAM_PARSER_DEFINES_SVH

// implication checked at every edge outside reset
`define NBT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define NBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/nbtp_pkg.sv =====
package nbtp_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int AW = $clog2(MAX_DEPTH);

    localparam logic [3:0] ROLE_TYPE = 4'd0;
    localparam logic [3:0] ROLE_NAMELEN = 4'd1;
    localparam logic [3:0] ROLE_NAMECHAR = 4'd2;
    localparam logic [3:0] ROLE_SCALAR = 4'd3;
    localparam logic [3:0] ROLE_LISTTYPE = 4'd4;
    localparam logic [3:0] ROLE_COUNT = 4'd5;
    localparam logic [3:0] ROLE_ARRBYTE = 4'd6;
    localparam logic [3:0] ROLE_STRLEN = 4'd7;
    localparam logic [3:0] ROLE_STRCHAR = 4'd8;
    localparam logic [3:0] ROLE_END = 4'd9;
    localparam logic [3:0] ROLE_IGNORED = 4'd10;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_ROOT = 2'd1;
    localparam logic [1:0] ERR_TYPE = 2'd2;
    localparam logic [1:0] ERR_DEEP = 2'd3;

    localparam logic [3:0] K_END = 4'd0;
    localparam logic [3:0] K_BYTE = 4'd1;
    localparam logic [3:0] K_SHORT = 4'd2;
    localparam logic [3:0] K_INT = 4'd3;
    localparam logic [3:0] K_LONG = 4'd4;
    localparam logic [3:0] K_FLOAT = 4'd5;
    localparam logic [3:0] K_DOUBLE = 4'd6;
    localparam logic [3:0] K_BARR = 4'd7;
    localparam logic [3:0] K_STRING = 4'd8;
    localparam logic [3:0] K_LIST = 4'd9;
    localparam logic [3:0] K_COMPOUND = 4'd10;
    localparam logic [3:0] K_IARR = 4'd11;

    typedef struct packed {
        logic [3:0]  byte_role;
        logic [3:0]  tag_kind;
        logic [4:0]  nest_depth;
        logic [63:0] value_bits;
        logic        value_valid;
        logic [4:0]  frames_closed;
        logic        document_done;
        logic [1:0]  error_code;
    } result_t;

    typedef struct packed {
        logic        is_list;
        logic [3:0]  elem;
        logic [31:0] rem;
    } frame_t;

endpackage

// ===== rtl/core/nbtp_in_fifo.sv =====
// two-entry input queue between the port and the parser engine
module nbtp_in_fifo (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] wdata,
    output logic       full,
    input  logic       rd,
    output logic       avail,
    output logic [7:0] rdata
);
    import nbtp_pkg::*;

    logic [7:0] mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd && avail)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(rd && avail);
        end
    end
endmodule

// ===== rtl/core/nbtp_engine.sv =====
// parser engine: one byte in, one result out; list completion walks the
// frame stack one frame a cycle
module nbtp_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [4:0]        cfg_wdata,
    input  logic              in_avail,
    input  logic [7:0]        in_byte,
    output logic              in_rd,
    output logic              res_valid,
    output nbtp_pkg::result_t res,
    input  logic              res_ready
);
    import nbtp_pkg::*;

    typedef enum logic [3:0] {
        PH_ROOT, PH_TYPE, PH_NAMELEN, PH_NAMECHAR, PH_SCALAR, PH_LISTTYPE,
        PH_COUNT, PH_ARRBYTE, PH_INTELEM, PH_STRLEN, PH_STRCHAR, PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_FIN, ST_START
    } seq_t;

    frame_t       stack_mem [MAX_DEPTH];
    phase_t       ph_reg;
    seq_t         seq_reg;
    logic [3:0]   kind_reg;
    logic [3:0]   left_reg;
    logic [63:0]  acc_reg;
    logic [31:0]  run_reg;
    logic [DW-1:0] sp_reg;
    logic [1:0]   err_reg;
    logic [4:0]   lim_reg;
    logic [3:0]   start_kind_reg;
    result_t      pend_reg;
    logic         res_valid_reg;
    result_t      res_reg;
    frame_t       top;
    logic [4:0]   lim_eff;
    logic [63:0]  acc_sh;
    logic [31:0]  cnt_n;
    logic [AW-1:0] top_idx;

    assign lim_eff = (lim_reg > 5'(MAX_DEPTH)) ? 5'(MAX_DEPTH) : lim_reg;
    assign top_idx = AW'(sp_reg - DW'(1));
    assign top     = stack_mem[top_idx];
    assign acc_sh  = {acc_reg[55:0], in_byte};
    assign cnt_n   = acc_sh[31] ? 32'd0 : acc_sh[31:0];
    assign in_rd   = (seq_reg == ST_IDLE) && in_avail && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res     = res_reg;

    function automatic logic [63:0] sext_val(logic [3:0] k, logic [63:0] v);
        logic [63:0] r;
        begin
            r = v;
            if (k == K_BYTE) r = {{56{v[7]}}, v[7:0]};
            else if (k == K_SHORT) r = {{48{v[15]}}, v[15:0]};
            else if (k == K_INT || k == K_IARR) r = {{32{v[31]}}, v[31:0]};
            else if (k == K_FLOAT) r = {32'd0, v[31:0]};
            return r;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (seq_reg == ST_IDLE && in_rd && ph_reg == PH_COUNT && left_reg == 4'd1
            && kind_reg == K_LIST && run_reg[7:0] != 8'd0 && cnt_n != 32'd0
            && run_reg[7:0] <= 8'd11 && 5'(sp_reg) < lim_eff && err_reg == ERR_NONE)
        begin
            stack_mem[AW'(sp_reg)] <= '{1'b1, run_reg[3:0], cnt_n};
        end
        else if (seq_reg == ST_START && start_kind_reg == K_COMPOUND
                 && 5'(sp_reg) < lim_eff)
        begin
            stack_mem[AW'(sp_reg)] <= '{1'b0, 4'd0, 32'd0};
        end
        else if (seq_reg == ST_FIN && sp_reg != '0 && top.is_list && top.rem != 32'd1)
        begin
            stack_mem[top_idx].rem <= top.rem - 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg         <= PH_ROOT;
            seq_reg        <= ST_IDLE;
            kind_reg       <= '0;
            left_reg       <= '0;
            acc_reg        <= '0;
            run_reg        <= '0;
            sp_reg         <= '0;
            err_reg        <= ERR_NONE;
            lim_reg        <= 5'd16;
            start_kind_reg <= '0;
            pend_reg       <= '0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin : eng
            result_t     r;
            result_t     ro;
            logic        rvo;
            logic [1:0]  eo;
            logic        fin;
            logic        st;
            logic [3:0]  sk;
            r    = '0;
            ro   = res_reg;
            rvo  = res_valid_reg && !res_ready;
            eo   = err_reg;
            fin  = 1'b0;
            st   = 1'b0;
            sk   = '0;
            if (cfg_we)
            begin
                lim_reg <= cfg_wdata;
            end
            unique case (seq_reg)
                ST_IDLE:
                begin
                    if (in_rd)
                    begin
                        r.byte_role = ROLE_IGNORED;
                        r.tag_kind  = kind_reg;
                        unique case (ph_reg)
                            PH_ROOT:
                            begin
                                r.byte_role = ROLE_TYPE;
                                r.tag_kind  = (in_byte <= 8'd11) ? in_byte[3:0] : 4'd0;
                                if (in_byte != 8'd10)
                                begin
                                    if (eo == ERR_NONE) eo = ERR_ROOT;
                                    ph_reg <= PH_HALT;
                                end
                                else
                                begin
                                    kind_reg <= K_COMPOUND;
                                    ph_reg   <= PH_NAMELEN;
                                    left_reg <= 4'd2;
                                    acc_reg  <= '0;
                                end
                            end
                            PH_TYPE:
                            begin
                                r.byte_role = ROLE_TYPE;
                                if (in_byte == 8'd0)
                                begin
                                    r.byte_role = ROLE_END;
                                    r.tag_kind  = K_END;
                                    r.frames_closed = 5'd1;
                                    if (sp_reg != '0) sp_reg <= sp_reg - DW'(1);
                                    fin = 1'b1;
                                end
                                else if (in_byte > 8'd11)
                                begin
                                    r.tag_kind = K_END;
                                    if (eo == ERR_NONE) eo = ERR_TYPE;
                                    ph_reg <= PH_HALT;
                                end
                                else
                                begin
                                    r.tag_kind = in_byte[3:0];
                                    kind_reg <= in_byte[3:0];
                                    ph_reg   <= PH_NAMELEN;
                                    left_reg <= 4'd2;
                                    acc_reg  <= '0;
                                end
                            end
                            PH_NAMELEN:
                            begin
                                r.byte_role = ROLE_NAMELEN;
                                acc_reg  <= acc_sh;
                                left_reg <= left_reg - 4'd1;
                                if (left_reg == 4'd1)
                                begin
                                    run_reg <= {16'd0, acc_sh[15:0]};
                                    if (acc_sh[15:0] == 16'd0)
                                    begin
                                        st = 1'b1;
                                        sk = kind_reg;
                                    end
                                    else ph_reg <= PH_NAMECHAR;
                                end
                            end
                            PH_NAMECHAR:
                            begin
                                r.byte_role = ROLE_NAMECHAR;
                                run_reg <= run_reg - 32'd1;
                                if (run_reg == 32'd1)
                                begin
                                    st = 1'b1;
                                    sk = kind_reg;
                                end
                            end
                            PH_SCALAR:
                            begin
                                r.byte_role = ROLE_SCALAR;
                                acc_reg  <= acc_sh;
                                left_reg <= left_reg - 4'd1;
                                if (left_reg == 4'd1)
                                begin
                                    r.value_valid = 1'b1;
                                    r.value_bits  = sext_val(kind_reg, acc_sh);
                                    fin = 1'b1;
                                end
                            end
                            PH_LISTTYPE:
                            begin
                                r.byte_role = ROLE_LISTTYPE;
                                run_reg  <= {24'd0, in_byte};
                                ph_reg   <= PH_COUNT;
                                left_reg <= 4'd4;
                                acc_reg  <= '0;
                            end
                            PH_COUNT:
                            begin
                                r.byte_role = ROLE_COUNT;
                                acc_reg  <= acc_sh;
                                left_reg <= left_reg - 4'd1;
                                if (left_reg == 4'd1)
                                begin
                                    if (kind_reg == K_LIST)
                                    begin
                                        if (run_reg[7:0] == 8'd0 || cnt_n == 32'd0)
                                            fin = 1'b1;
                                        else if (run_reg[7:0] > 8'd11)
                                        begin
                                            if (eo == ERR_NONE) eo = ERR_TYPE;
                                            ph_reg <= PH_HALT;
                                        end
                                        else if (5'(sp_reg) >= lim_eff)
                                        begin
                                            if (eo == ERR_NONE) eo = ERR_DEEP;
                                            ph_reg <= PH_HALT;
                                        end
                                        else
                                        begin
                                            sp_reg <= sp_reg + DW'(1);
                                            st = 1'b1;
                                            sk = run_reg[3:0];
                                        end
                                    end
                                    else if (cnt_n == 32'd0)
                                        fin = 1'b1;
                                    else
                                    begin
                                        run_reg  <= cnt_n;
                                        acc_reg  <= '0;
                                        left_reg <= 4'd4;
                                        ph_reg   <= (kind_reg == K_IARR) ? PH_INTELEM
                                                                         : PH_ARRBYTE;
                                    end
                                end
                            end
                            PH_ARRBYTE:
                            begin
                                r.byte_role = ROLE_ARRBYTE;
                                run_reg <= run_reg - 32'd1;
                                if (run_reg == 32'd1) fin = 1'b1;
                            end
                            PH_INTELEM:
                            begin
                                r.byte_role = ROLE_ARRBYTE;
                                acc_reg  <= acc_sh;
                                left_reg <= left_reg - 4'd1;
                                if (left_reg == 4'd1)
                                begin
                                    r.value_valid = 1'b1;
                                    r.value_bits  = sext_val(K_INT, acc_sh);
                                    acc_reg  <= '0;
                                    left_reg <= 4'd4;
                                    run_reg  <= run_reg - 32'd1;
                                    if (run_reg == 32'd1) fin = 1'b1;
                                end
                            end
                            PH_STRLEN:
                            begin
                                r.byte_role = ROLE_STRLEN;
                                acc_reg  <= acc_sh;
                                left_reg <= left_reg - 4'd1;
                                if (left_reg == 4'd1)
                                begin
                                    run_reg <= {16'd0, acc_sh[15:0]};
                                    if (acc_sh[15:0] == 16'd0) fin = 1'b1;
                                    else ph_reg <= PH_STRCHAR;
                                end
                            end
                            PH_STRCHAR:
                            begin
                                r.byte_role = ROLE_STRCHAR;
                                run_reg <= run_reg - 32'd1;
                                if (run_reg == 32'd1) fin = 1'b1;
                            end
                            default:
                            begin
                                r.byte_role = ROLE_IGNORED;
                                r.tag_kind  = K_END;
                                ph_reg      <= PH_HALT;
                            end
                        endcase
                        if (fin)
                        begin
                            seq_reg  <= ST_FIN;
                            pend_reg <= r;
                        end
                        else if (st)
                        begin
                            seq_reg        <= ST_START;
                            start_kind_reg <= sk;
                            pend_reg       <= r;
                        end
                        else
                        begin
                            // error raised on this byte shows in the result
                            r.nest_depth = 5'(sp_reg);
                            r.error_code = eo;
                            ro  = r;
                            rvo = 1'b1;
                        end
                    end
                end
                ST_FIN:
                begin
                    // one frame per cycle
                    if (sp_reg == '0)
                    begin
                        pend_reg.document_done <= 1'b1;
                        ph_reg   <= PH_ROOT;
                        kind_reg <= '0;
                        seq_reg  <= ST_IDLE;
                        ro  = '{pend_reg.byte_role, pend_reg.tag_kind, 5'd0,
                                pend_reg.value_bits, pend_reg.value_valid,
                                pend_reg.frames_closed, 1'b1, err_reg};
                        rvo = 1'b1;
                    end
                    else if (!top.is_list)
                    begin
                        ph_reg   <= PH_TYPE;
                        kind_reg <= K_COMPOUND;
                        seq_reg  <= ST_IDLE;
                        ro  = '{pend_reg.byte_role, pend_reg.tag_kind, 5'(sp_reg),
                                pend_reg.value_bits, pend_reg.value_valid,
                                pend_reg.frames_closed, 1'b0, err_reg};
                        rvo = 1'b1;
                    end
                    else if (top.rem == 32'd1)
                    begin
                        sp_reg <= sp_reg - DW'(1);
                        pend_reg.frames_closed <= pend_reg.frames_closed + 5'd1;
                    end
                    else
                    begin
                        seq_reg        <= ST_START;
                        start_kind_reg <= top.elem;
                    end
                end
                ST_START:
                begin
                    kind_reg <= start_kind_reg;
                    acc_reg  <= '0;
                    seq_reg  <= ST_IDLE;
                    rvo = 1'b1;
                    ro  = '{pend_reg.byte_role, pend_reg.tag_kind, 5'(sp_reg),
                            pend_reg.value_bits, pend_reg.value_valid,
                            pend_reg.frames_closed, 1'b0, err_reg};
                    case (start_kind_reg)
                        K_BYTE, K_SHORT, K_INT, K_LONG, K_FLOAT, K_DOUBLE:
                        begin
                            ph_reg <= PH_SCALAR;
                            unique case (start_kind_reg)
                                K_BYTE:  left_reg <= 4'd1;
                                K_SHORT: left_reg <= 4'd2;
                                K_LONG, K_DOUBLE: left_reg <= 4'd8;
                                default: left_reg <= 4'd4;
                            endcase
                        end
                        K_BARR, K_IARR:
                        begin
                            ph_reg   <= PH_COUNT;
                            left_reg <= 4'd4;
                        end
                        K_STRING:
                        begin
                            ph_reg   <= PH_STRLEN;
                            left_reg <= 4'd2;
                        end
                        K_LIST: ph_reg <= PH_LISTTYPE;
                        K_COMPOUND:
                        begin
                            if (5'(sp_reg) < lim_eff)
                            begin
                                sp_reg <= sp_reg + DW'(1);
                                ph_reg <= PH_TYPE;
                                ro.nest_depth = 5'(sp_reg) + 5'd1;
                            end
                            else
                            begin
                                if (eo == ERR_NONE)
                                begin
                                    eo = ERR_DEEP;
                                    ro.error_code = ERR_DEEP;
                                end
                                ph_reg <= PH_HALT;
                            end
                        end
                        default:
                        begin
                            if (eo == ERR_NONE)
                            begin
                                eo = ERR_TYPE;
                                ro.error_code = ERR_TYPE;
                            end
                            ph_reg <= PH_HALT;
                        end
                    endcase
                end
                default: seq_reg <= ST_IDLE;
            endcase
            res_reg       <= ro;
            res_valid_reg <= rvo;
            err_reg       <= eo;
        end
    end
endmodule

// ===== rtl/core/nbtp_out_fifo.sv =====
// two-entry result queue
module nbtp_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  nbtp_pkg::result_t wdata,
    output logic              ready,
    input  logic              pop,
    output logic              empty,
    output nbtp_pkg::result_t rdata
);
    import nbtp_pkg::*;

    result_t    mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign ready = (cnt_reg != 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && ready)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr && ready) wp_reg <= !wp_reg;
            if (pop && !empty) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr && ready) - 2'(pop && !empty);
        end
    end
endmodule

// ===== rtl/core/named_binary_tag_stream_parser.sv =====
// path: a byte goes through the input queue, the engine result register
// and the result queue; a byte that ends a tag also passes the finish
// state, once more per list frame it closes, and starting a body or the
// next list element passes the start state; throughput: one byte per cycle
// on plain bytes while the result queue has room, and none in those states
// reset: rst_n clears all control state asynchronously; depth_limit goes to 16
module named_binary_tag_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  data_byte,
    output logic        full,
    input  logic        cfg_we,
    input  logic [4:0]  depth_limit,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  byte_role,
    output logic [3:0]  tag_kind,
    output logic [4:0]  nest_depth,
    output logic [63:0] value_bits,
    output logic        value_valid,
    output logic [4:0]  frames_closed,
    output logic        document_done,
    output logic [1:0]  error_code
);
    import nbtp_pkg::*;

    logic    avail;
    logic    rd;
    logic [7:0] b;
    logic    rv;
    result_t r;
    result_t q;
    logic    rdy;
    logic    ov;

    nbtp_in_fifo u_in (
        .clk(clk), .rst_n(rst_n), .push(push), .wdata(data_byte), .full(full),
        .rd(rd), .avail(avail), .rdata(b)
    );

    nbtp_engine u_eng (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(depth_limit),
        .in_avail(avail), .in_byte(b), .in_rd(rd), .res_valid(rv), .res(r),
        .res_ready(ov)
    );

    // engine holds one result; forward it only once the queue has room
    assign ov = rdy;

    nbtp_out_fifo u_out (
        .clk(clk), .rst_n(rst_n), .wr(rv), .wdata(r), .ready(rdy),
        .pop(pop), .empty(empty), .rdata(q)
    );

    assign byte_role     = q.byte_role;
    assign tag_kind      = q.tag_kind;
    assign nest_depth    = q.nest_depth;
    assign value_bits    = q.value_bits;
    assign value_valid   = q.value_valid;
    assign frames_closed = q.frames_closed;
    assign document_done = q.document_done;
    assign error_code    = q.error_code;
endmodule

// ===== rtl/core/nbtp_checker.sv =====
module nbtp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       value_valid,
    input logic [63:0] value_bits,
    input logic [1:0] error_code,
    input logic       document_done,
    input logic [4:0] nest_depth,
    input logic [4:0] frames_closed
);
    `include "named_binary_tag_stream_parser_defines.svh"

    `NBT_ASSERT_IMPL(a_done_depth, clk, rst_n, !empty && document_done, nest_depth == 5'd0)
    `NBT_ASSERT_IMPL(a_val_zero, clk, rst_n, !empty && !value_valid, value_bits == 64'd0)
    `NBT_ASSERT_IMPL(a_err_quiet, clk, rst_n, !empty && error_code != 2'd0,
        !value_valid && !document_done)
    `NBT_ASSERT_NEXT(a_err_sticky, clk, rst_n, !empty && pop && error_code != 2'd0,
        empty || error_code != 2'd0)
    `NBT_ASSERT_IMPL(a_closed_max, clk, rst_n, !empty, frames_closed <= 5'd16)
endmodule

bind named_binary_tag_stream_parser nbtp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .value_valid(value_valid),
    .value_bits(value_bits), .error_code(error_code), .document_done(document_done),
    .nest_depth(nest_depth), .frames_closed(frames_closed)
);
